@@ rtl/message_to_tcp_tx_bridge_defines.svh @@
// Assertion macros shared by the bridge modules.
`ifndef MESSAGE_TO_TCP_TX_BRIDGE_DEFINES_SVH
`define MESSAGE_TO_TCP_TX_BRIDGE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define MTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bridge assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define MTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bridge assertion failed");
`else
`define MTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/mtb_pkg.sv @@
package mtb_pkg;

    // Input operation codes
    localparam logic [2:0] OP_MSG_WORD = 3'd0;
    localparam logic [2:0] OP_LOOKUP_ANS = 3'd1;
    localparam logic [2:0] OP_NEW_SESSION = 3'd2;
    localparam logic [2:0] OP_SEND_STATUS = 3'd3;
    localparam logic [2:0] OP_NODE_WR = 3'd4;
    localparam logic [2:0] OP_ADDR_WR = 3'd5;

    // Result kinds
    localparam logic [2:0] K_LOOKUP = 3'd0;
    localparam logic [2:0] K_OPEN = 3'd1;
    localparam logic [2:0] K_STORE = 3'd2;
    localparam logic [2:0] K_META = 3'd3;
    localparam logic [2:0] K_DATA = 3'd4;
    localparam logic [2:0] K_REFUSED = 3'd5;

    // Configuration register indexes
    localparam logic REG_OWN_NODE = 1'b0;
    localparam logic REG_EMPTY_MARKER = 1'b1;

    localparam logic [15:0] EMPTY_MARKER_RESET = 16'h03e8;

    // Decoded work for one accepted item; a second metadata result follows when two is set
    typedef struct packed {
        logic [2:0]  kind;
        logic        two;
        logic [15:0] session;
        logic [15:0] length;
        logic [63:0] data;
        logic        last;
    } mtb_item_t;

endpackage

@@ rtl/mtb_maps.sv @@
module mtb_maps #(
    parameter int MAP_DEPTH = 256
) (
    input  logic        clk,
    input  logic        wr_node,
    input  logic        wr_addr,
    input  logic [7:0]  wr_index,
    input  logic [31:0] wr_value,
    input  logic        rd_en,
    input  logic [7:0]  rd_index,
    output logic [7:0]  rd_key,
    output logic [31:0] rd_ip
);
    import mtb_pkg::*;

    localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam logic [8:0] DEPTH_LIM = 9'(MAP_DEPTH);

    logic [7:0]  node_mem [MAP_DEPTH];
    logic [31:0] addr_mem [MAP_DEPTH];
    logic [7:0]  key_q;
    logic [31:0] ip_q;
    logic        range_q;
    logic        wr_ok;
    logic        rd_ok;

    assign wr_ok = {1'b0, wr_index} < DEPTH_LIM;
    assign rd_ok = {1'b0, rd_index} < DEPTH_LIM;

    always_ff @(posedge clk)
    begin
        if (wr_node && wr_ok)
        begin
            node_mem[wr_index[AW-1:0]] <= wr_value[7:0];
        end
        if (wr_addr && wr_ok)
        begin
            addr_mem[wr_index[AW-1:0]] <= wr_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            key_q   <= node_mem[rd_index[AW-1:0]];
            ip_q    <= addr_mem[rd_index[AW-1:0]];
            range_q <= rd_ok;
        end
    end

    // Destinations past the map depth read as zero
    assign rd_key = range_q ? key_q : 8'd0;
    assign rd_ip  = range_q ? ip_q : 32'd0;

endmodule

@@ rtl/mtb_ctrl.sv @@
`include "message_to_tcp_tx_bridge_defines.svh"

module mtb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [2:0]         operation,
    input  logic [63:0]        word_data,
    input  logic               word_last,
    input  logic [15:0]        in_session,
    input  logic signed [16:0] send_status,
    input  logic [7:0]         own_node,
    input  logic [15:0]        empty_marker,
    output logic [7:0]         rd_index,
    output mtb_pkg::mtb_item_t item
);
    import mtb_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LOOKUP,
        PH_SESSION,
        PH_STATUS,
        PH_STREAM
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [63:0] header_word_reg, header_word_next;
    logic        header_last_reg, header_last_next;
    logic [7:0]  destination_reg, destination_next;
    logic [15:0] session_reg, session_next;
    logic [15:0] meta_len;
    logic [63:0] hdr_new;

    // Bytes = (size + 1) * 8, wrapped to 16 bits
    assign meta_len = {header_word_reg[12:0] + 13'd1, 3'b000};
    assign hdr_new  = {word_data[63:24], own_node, word_data[15:0]};

    assign rd_index = (phase_reg == PH_IDLE && operation == OP_MSG_WORD)
                    ? word_data[31:24] : destination_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        header_word_next = header_word_reg;
        header_last_next = header_last_reg;
        destination_next = destination_reg;
        session_next     = session_reg;
        item             = '0;
        item.kind        = K_REFUSED;
        case (phase_reg)
            PH_IDLE:
            begin
                if (operation == OP_MSG_WORD)
                begin
                    header_word_next = hdr_new;
                    header_last_next = word_last;
                    destination_next = hdr_new[31:24];
                    item.kind        = K_LOOKUP;
                    phase_next       = PH_LOOKUP;
                end
            end
            PH_LOOKUP:
            begin
                if (operation == OP_LOOKUP_ANS)
                begin
                    session_next = in_session;
                    if (in_session == empty_marker)
                    begin
                        item.kind  = K_OPEN;
                        phase_next = PH_SESSION;
                    end
                    else
                    begin
                        item.kind    = K_META;
                        item.session = in_session;
                        item.length  = meta_len;
                        phase_next   = PH_STATUS;
                    end
                end
            end
            PH_SESSION:
            begin
                if (operation == OP_NEW_SESSION)
                begin
                    session_next = in_session;
                    item.kind    = K_STORE;
                    item.two     = 1'b1;
                    item.session = in_session;
                    item.length  = meta_len;
                    phase_next   = PH_STATUS;
                end
            end
            PH_STATUS:
            begin
                if (operation == OP_SEND_STATUS)
                begin
                    if (send_status[16])
                    begin
                        // Engine busy: resend metadata
                        item.kind    = K_META;
                        item.session = session_reg;
                        item.length  = meta_len;
                    end
                    else
                    begin
                        item.kind  = K_DATA;
                        item.data  = header_word_reg;
                        item.last  = header_last_reg;
                        phase_next = header_last_reg ? PH_IDLE : PH_STREAM;
                    end
                end
            end
            PH_STREAM:
            begin
                if (operation == OP_MSG_WORD)
                begin
                    item.kind = K_DATA;
                    item.data = word_data;
                    item.last = word_last;
                    if (word_last)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            header_word_reg <= '0;
            header_last_reg <= 1'b0;
            destination_reg <= '0;
            session_reg     <= '0;
        end
        else if (accept && operation != OP_NODE_WR && operation != OP_ADDR_WR)
        begin
            phase_reg       <= phase_next;
            header_word_reg <= header_word_next;
            header_last_reg <= header_last_next;
            destination_reg <= destination_next;
            session_reg     <= session_next;
        end
    end

    `MTB_ASSERT_NXT(a_stream_last_idle, clk, rst_n,
        accept && phase_reg == PH_STREAM && operation == OP_MSG_WORD && word_last,
        phase_reg == PH_IDLE)
    `MTB_ASSERT_NXT(a_map_keeps_phase, clk, rst_n,
        accept && (operation == OP_NODE_WR || operation == OP_ADDR_WR),
        $stable(phase_reg))

endmodule

@@ rtl/mtb_out.sv @@
`include "message_to_tcp_tx_bridge_defines.svh"

module mtb_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load_item,
    input  mtb_pkg::mtb_item_t item,
    input  logic [7:0]         rd_key,
    input  logic [31:0]        rd_ip,
    output logic               busy,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         kind,
    output logic [7:0]         lookup_key,
    output logic [31:0]        peer_ip,
    output logic [15:0]        out_session,
    output logic [15:0]        send_length,
    output logic [63:0]        out_data,
    output logic               out_last,
    output logic               final_result
);
    import mtb_pkg::*;

    mtb_item_t   s1_reg;
    logic        s1_valid_reg;
    logic        s1_beat_reg;
    logic        load;
    logic        s1_done;

    logic [2:0]  r_kind;
    logic [7:0]  r_key;
    logic [31:0] r_ip;
    logic [15:0] r_session;
    logic [15:0] r_length;
    logic [63:0] r_data;
    logic        r_last;
    logic        r_final;

    logic        out_valid_reg;
    logic [2:0]  kind_reg;
    logic [7:0]  key_reg;
    logic [31:0] ip_reg;
    logic [15:0] session_reg;
    logic [15:0] length_reg;
    logic [63:0] data_reg;
    logic        last_reg;
    logic        final_reg;

    assign load    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_done = load && (!s1_reg.two || s1_beat_reg);
    assign busy    = s1_valid_reg && !s1_done;

    always_comb
    begin
        r_kind    = s1_reg.kind;
        r_key     = '0;
        r_ip      = '0;
        r_session = '0;
        r_length  = '0;
        r_data    = '0;
        r_last    = 1'b0;
        r_final   = !s1_reg.two || s1_beat_reg;
        if (s1_beat_reg)
        begin
            r_kind = K_META;
        end
        if (r_kind == K_LOOKUP || r_kind == K_STORE)
        begin
            r_key = rd_key;
        end
        if (r_kind == K_OPEN)
        begin
            r_ip = rd_ip;
        end
        if (r_kind == K_STORE || r_kind == K_META)
        begin
            r_session = s1_reg.session;
        end
        if (r_kind == K_META)
        begin
            r_length = s1_reg.length;
        end
        if (r_kind == K_DATA)
        begin
            r_data = s1_reg.data;
            r_last = s1_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_beat_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_item)
            begin
                s1_valid_reg <= 1'b1;
                s1_beat_reg  <= 1'b0;
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
                s1_beat_reg  <= 1'b0;
            end
            else if (load)
            begin
                s1_beat_reg <= 1'b1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            s1_reg <= item;
        end
        if (load)
        begin
            kind_reg    <= r_kind;
            key_reg     <= r_key;
            ip_reg      <= r_ip;
            session_reg <= r_session;
            length_reg  <= r_length;
            data_reg    <= r_data;
            last_reg    <= r_last;
            final_reg   <= r_final;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign lookup_key   = key_reg;
    assign peer_ip      = ip_reg;
    assign out_session  = session_reg;
    assign send_length  = length_reg;
    assign out_data     = data_reg;
    assign out_last     = last_reg;
    assign final_result = final_reg;

    `MTB_ASSERT_IMP(a_beat_needs_two, clk, rst_n,
        s1_beat_reg, s1_valid_reg && s1_reg.two)
    `MTB_ASSERT_NXT(a_first_beat_holds, clk, rst_n,
        load && !s1_done, s1_valid_reg && s1_beat_reg)
    `MTB_ASSERT_NXT(a_second_is_meta, clk, rst_n,
        load && s1_beat_reg, out_valid_reg && kind_reg == K_META && final_reg)

endmodule

@@ rtl/message_to_tcp_tx_bridge.sv @@
// Message-to-TCP transmit bridge.
// Input channel (in_valid / in_stall) carries message words, engine answers
// (lookup answer, new session, send status) and map writes, picked by operation.
// Output channel (out_valid / out_stall) carries the requests and data words
// for the TCP engine; final_result marks the last result of one input item.
// Configuration channel (cfg_valid / cfg_ready, always ready) writes own_node
// (index 0) and empty_marker (index 1); write only while the block is idle.
// A result passes through the issue stage and then the output register before
// it is offered on the output channel.
// Throughput: one item per cycle while out_stall is low; a new-connection session
// gives two results and holds the input until both issue. Map writes give no result.
// The maps live in two synchronous memories read at the accepted edge; the
// read data lines up with the issue stage, which loads at that same edge.
// Reset clears the phase to idle, own_node to 0 and empty_marker to 1000;
// map contents stay undefined until written.
// When the receiver stalls, the output register holds, the issue stage fills
// behind it, and then in_stall rises; nothing is dropped.
module message_to_tcp_tx_bridge #(
    parameter int MAP_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         operation,
    input  logic [63:0]        word_data,
    input  logic               word_last,
    input  logic [15:0]        in_session,
    input  logic signed [16:0] send_status,
    input  logic [7:0]         map_index,
    input  logic [31:0]        map_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         kind,
    output logic [7:0]         lookup_key,
    output logic [31:0]        peer_ip,
    output logic [15:0]        out_session,
    output logic [15:0]        send_length,
    output logic [63:0]        out_data,
    output logic               out_last,
    output logic               final_result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);
    import mtb_pkg::*;

    logic       accept;
    logic       is_map_wr;
    logic       busy;
    logic [7:0] rd_index;
    logic [7:0] rd_key;
    logic [31:0] rd_ip;
    mtb_item_t  item;

    logic [7:0]  own_node_reg;
    logic [15:0] empty_marker_reg;

    // Transfer on the input side whenever the issue stage is free or draining
    assign in_stall  = busy;
    assign accept    = in_valid && !in_stall;
    assign is_map_wr = (operation == OP_NODE_WR) || (operation == OP_ADDR_WR);
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_node_reg     <= '0;
            empty_marker_reg <= EMPTY_MARKER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OWN_NODE:     own_node_reg <= cfg_data[7:0];
                REG_EMPTY_MARKER: empty_marker_reg <= cfg_data;
                default:          own_node_reg <= own_node_reg;
            endcase
        end
    end

    // Destination maps: write on map transfers, read on every accepted item
    mtb_maps #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_maps (
        .clk      (clk),
        .wr_node  (accept && operation == OP_NODE_WR),
        .wr_addr  (accept && operation == OP_ADDR_WR),
        .wr_index (map_index),
        .wr_value (map_value),
        .rd_en    (accept),
        .rd_index (rd_index),
        .rd_key   (rd_key),
        .rd_ip    (rd_ip)
    );

    // Phase tracking and decode of each item
    mtb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .operation    (operation),
        .word_data    (word_data),
        .word_last    (word_last),
        .in_session   (in_session),
        .send_status  (send_status),
        .own_node     (own_node_reg),
        .empty_marker (empty_marker_reg),
        .rd_index     (rd_index),
        .item         (item)
    );

    // Issue stage and output register; map writes skip the issue stage
    mtb_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_item    (accept && !is_map_wr),
        .item         (item),
        .rd_key       (rd_key),
        .rd_ip        (rd_ip),
        .busy         (busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .lookup_key   (lookup_key),
        .peer_ip      (peer_ip),
        .out_session  (out_session),
        .send_length  (send_length),
        .out_data     (out_data),
        .out_last     (out_last),
        .final_result (final_result)
    );

endmodule
